FILE: rtl/granular_loop_player_defines.svh
// Assertion helpers for the RTL; included by granular_loop_player.sv.
`ifndef GRANULAR_LOOP_PLAYER_DEFINES_SVH
`define GRANULAR_LOOP_PLAYER_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define GLP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define GLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/glp_pkg.sv
package glp_pkg;

  localparam int MAX_GRAINS_DEF  = 128;
  localparam int LOOP_FRAMES_DEF = 65536;

  // Divider operand widths
  localparam int NUM_W = 45;
  localparam int DEN_W = 33;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 17;
  localparam int LIFE_W    = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASTER_GAIN    = 3'd0,
    CFG_ACTIVE_GRAINS  = 3'd1,
    CFG_LOOP_LENGTH    = 3'd2,
    CFG_FREEZE         = 3'd3,
    CFG_GRAIN_SPACING  = 3'd4,
    CFG_GRAIN_LENGTH   = 3'd5,
    CFG_GRAIN_LIFETIME = 3'd6,
    CFG_GRAIN_SPEED    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: rtl/glp_ram.sv
module glp_ram #(
  parameter int W = 32,
  parameter int D = 256
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                      wdata_i,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                      rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/glp_div.sv
module glp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  glp_pkg::div_req_t req_i,
  output glp_pkg::div_rsp_t rsp_o
);

  import glp_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic             qbit;

  always_comb begin
    trial  = {rem_q, quo_q[NUM_W-1]};
    qbit   = 1'b0;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (busy_q) begin
      // restoring step: one quotient bit per cycle
      if (trial >= {1'b0, den_q}) begin
        rem_d = DEN_W'(trial - {1'b0, den_q});
        qbit  = 1'b1;
      end else begin
        rem_d = trial[DEN_W-1:0];
      end
      quo_d = {quo_q[NUM_W-2:0], qbit};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = CW'(NUM_W);
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: rtl/granular_loop_player.sv
// Stereo granular loop player.
// Input stream (s_axis_*): one stereo frame plus four jitter offsets per
// transaction. Output stream (m_axis_*): one saturated stereo frame per input.
// Config channel (cfg_*): register index and data, always ready; write it only
// while the block is idle.
// Each input walks the active grain slots on one shared 33x33 multiplier:
// a live grain passes through WALK, GLOAD, GFRAME and GM1 to GM5, a free slot
// only through WALK. A grain start adds three 45-step divisions on the serial
// divider, five multiply steps and the slot write; s_axis_tready is high only
// between items.
// The result sits in an output register; the next input is accepted while it
// waits. If the receiver stalls, the block holds in its final step until the
// previous result is taken.
// Reset: registers return to defaults, all grains free, then a clearing pass
// writes zero to every loop frame before the first input is accepted.
`include "granular_loop_player_defines.svh"

module granular_loop_player #(
  parameter int MAX_GRAINS  = glp_pkg::MAX_GRAINS_DEF,
  parameter int LOOP_FRAMES = glp_pkg::LOOP_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // left_in, right_in, start_offset, speed_offset, length_offset, life_offset
  input  logic [95:0]                   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // left_out, right_out
  output logic [31:0]                   m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [glp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [glp_pkg::CFG_W-1:0]     cfg_data_i
);

  import glp_pkg::*;

  localparam int FA    = $clog2(LOOP_FRAMES);
  localparam int LW    = $clog2(LOOP_FRAMES + 1);
  localparam int PW    = FA + 12;
  localparam int EW    = LW + 12;
  localparam int SW    = EW + 1;
  localparam int GA    = MAX_GRAINS > 1 ? $clog2(MAX_GRAINS) : 1;
  localparam int GI    = $clog2(MAX_GRAINS + 1);
  localparam int ACC_W = 47 + GI;
  localparam int ML_W  = ACC_W - 30;

  typedef struct packed {
    logic [PW-1:0]     pos;
    logic [PW-1:0]     beg_pos;
    logic [EW-1:0]     end_pos;
    logic [LIFE_W-1:0] life;
    logic [15:0]       rate;
    logic [31:0]       ph_len;
    logic [31:0]       step_len;
    logic [31:0]       ph_life;
    logic [31:0]       step_life;
  } grain_t;

  localparam int GW = $bits(grain_t);

  typedef enum logic [22:0] {
    ST_CLEAR  = 23'd1 << 0,
    ST_IDLE   = 23'd1 << 1,
    ST_WALK   = 23'd1 << 2,
    ST_GLOAD  = 23'd1 << 3,
    ST_GFRAME = 23'd1 << 4,
    ST_GM1    = 23'd1 << 5,
    ST_GM2    = 23'd1 << 6,
    ST_GM3    = 23'd1 << 7,
    ST_GM4    = 23'd1 << 8,
    ST_GM5    = 23'd1 << 9,
    ST_SPAWN  = 23'd1 << 10,
    ST_SM0    = 23'd1 << 11,
    ST_SM1    = 23'd1 << 12,
    ST_SM2    = 23'd1 << 13,
    ST_SM3    = 23'd1 << 14,
    ST_SM4    = 23'd1 << 15,
    ST_DV0    = 23'd1 << 16,
    ST_DV1    = 23'd1 << 17,
    ST_DV2    = 23'd1 << 18,
    ST_SPWR   = 23'd1 << 19,
    ST_FINISH = 23'd1 << 20,
    ST_OUTL   = 23'd1 << 21,
    ST_OUTR   = 23'd1 << 22
  } state_e;

  function automatic logic [15:0] sat16(input logic signed [65:0] v);
    logic signed [65:0] s;
    s = v >>> 12;
    if (s > 66'sd32767) begin
      return 16'h7FFF;
    end else if (s < -66'sd32768) begin
      return 16'h8000;
    end
    return s[15:0];
  endfunction

  // configuration
  logic [13:0] gain_q;
  logic [7:0]  act_q;
  logic [16:0] loop_len_q;
  logic        freeze_q;
  logic [15:0] spacing_q, glen_q, glife_q, speed_q;

  // control
  state_e                   state_q, state_d;
  logic [FA-1:0]            clr_q, clr_d;
  logic [GI-1:0]            idx_q, idx_d;
  logic [GA-1:0]            free_q, free_d;
  logic                     found_q, found_d;
  logic [MAX_GRAINS-1:0]    live_q, live_d;
  logic [FA-1:0]            wi_q, wi_d;
  logic signed [16:0]       cd_q, cd_d;
  logic                     m_valid_q, m_valid_d;

  // datapath
  logic [15:0]              lft_q, rgt_q, fs_q, fp_q, fl_q, fd_q;
  logic signed [ACC_W-1:0]  acc_l_q, acc_l_d, acc_r_q, acc_r_d;
  grain_t                   w_q, w_d;
  logic [16:0]              gl_q, gl_d;
  logic [30:0]              g_q, g_d;
  logic [31:0]              word_q, word_d;
  logic [FA+12:0]           st_raw_q, st_raw_d;
  logic [28:0]              siz_q, siz_d, du_q, du_d;
  logic [15:0]              rate_q, rate_d;
  logic [PW-1:0]            st_q, st_d;
  logic [31:0]              stl_q, stl_d, std_q, std_d;
  logic [15:0]              tmp_l_q, tmp_l_d;
  logic [31:0]              m_data_q, m_data_d;

  logic signed [32:0]       ma, mb;
  logic signed [65:0]       p_q;

  logic [LW-1:0]            len_l;
  logic [EW-1:0]            lq;
  logic [GI-1:0]            n_grains;

  grain_t                   g_rd, g_wr;
  logic                     g_we;
  logic [GA-1:0]            g_waddr;
  logic [GW-1:0]            g_rdata;

  logic                     l_we;
  logic [FA-1:0]            l_waddr;
  logic [31:0]              l_wdata, l_rdata;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  logic [SW-1:0]            sum;
  logic [LIFE_W-1:0]        life_n;
  logic [LW:0]              wi_inc;
  logic [33:0]              en_ext;
  logic [29:0]              life_sum;
  logic signed [ML_W-1:0]   ml_l, ml_r;
  logic [31:0]              nph;

  assign ml_l = acc_l_q[ACC_W-1:30];
  assign ml_r = acc_r_q[ACC_W-1:30];
  assign g_rd = grain_t'(g_rdata);

  always_comb begin
    if (loop_len_q == 17'd0) begin
      len_l = LW'(1);
    end else if (32'(loop_len_q) > 32'(LOOP_FRAMES)) begin
      len_l = LW'(LOOP_FRAMES);
    end else begin
      len_l = LW'(loop_len_q);
    end
    lq = {len_l, 12'd0};
    if (32'(act_q) > 32'(MAX_GRAINS)) begin
      n_grains = GI'(MAX_GRAINS);
    end else begin
      n_grains = GI'(act_q);
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= 14'd2048;
      act_q      <= 8'd10;
      loop_len_q <= 17'd48000;
      freeze_q   <= 1'b0;
      spacing_q  <= 16'd960;
      glen_q     <= 16'd1440;
      glife_q    <= 16'd14400;
      speed_q    <= 16'd4096;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MASTER_GAIN:    gain_q     <= cfg_data_i[13:0];
        CFG_ACTIVE_GRAINS:  act_q      <= cfg_data_i[7:0];
        CFG_LOOP_LENGTH:    loop_len_q <= cfg_data_i[16:0];
        CFG_FREEZE:         freeze_q   <= cfg_data_i[0];
        CFG_GRAIN_SPACING:  spacing_q  <= cfg_data_i[15:0];
        CFG_GRAIN_LENGTH:   glen_q     <= cfg_data_i[15:0];
        CFG_GRAIN_LIFETIME: glife_q    <= cfg_data_i[15:0];
        CFG_GRAIN_SPEED:    speed_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    idx_d     = idx_q;
    free_d    = free_q;
    found_d   = found_q;
    live_d    = live_q;
    wi_d      = wi_q;
    cd_d      = cd_q;
    m_valid_d = m_valid_q & ~m_axis_tready;
    acc_l_d   = acc_l_q;
    acc_r_d   = acc_r_q;
    w_d       = w_q;
    gl_d      = gl_q;
    g_d       = g_q;
    word_d    = word_q;
    st_raw_d  = st_raw_q;
    siz_d     = siz_q;
    du_d      = du_q;
    rate_d    = rate_q;
    st_d      = st_q;
    stl_d     = stl_q;
    std_d     = std_q;
    tmp_l_d   = tmp_l_q;
    m_data_d  = m_data_q;
    ma        = '0;
    mb        = '0;
    g_we      = 1'b0;
    g_waddr   = idx_q[GA-1:0];
    g_wr      = w_q;
    l_we      = 1'b0;
    l_waddr   = wi_q;
    l_wdata   = {rgt_q, lft_q};
    div_req   = '0;
    sum       = '0;
    life_n    = '0;
    wi_inc    = '0;
    en_ext    = '0;
    life_sum  = '0;
    nph       = '0;

    unique case (state_q)
      ST_CLEAR: begin
        l_we    = 1'b1;
        l_waddr = clr_q;
        l_wdata = '0;
        clr_d   = clr_q + FA'(1);
        if (clr_q == FA'(LOOP_FRAMES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          acc_l_d = '0;
          acc_r_d = '0;
          idx_d   = '0;
          found_d = 1'b0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (idx_q == n_grains) begin
          state_d = ST_SPAWN;
        end else if (live_q[idx_q[GA-1:0]]) begin
          state_d = ST_GLOAD;
        end else begin
          free_d  = idx_q[GA-1:0];
          found_d = 1'b1;
          idx_d   = idx_q + GI'(1);
        end
      end
      ST_GLOAD: begin
        sum = SW'(g_rd.pos) + SW'(g_rd.rate);
        if (sum >= SW'(g_rd.end_pos)) begin
          sum = SW'(g_rd.beg_pos);
        end
        if (sum >= SW'(lq)) begin
          sum = sum - SW'(lq);
        end
        w_d         = g_rd;
        w_d.pos     = PW'(sum);
        w_d.ph_len  = g_rd.ph_len + g_rd.step_len;
        w_d.ph_life = g_rd.ph_life + g_rd.step_life;
        life_n      = (g_rd.life != '0) ? g_rd.life - LIFE_W'(1) : '0;
        w_d.life    = life_n;
        // the grain still sounds on the step where its life runs out
        if (life_n == '0) begin
          live_d[idx_q[GA-1:0]] = 1'b0;
        end
        state_d = ST_GFRAME;
      end
      ST_GFRAME: begin
        nph     = ~w_q.ph_len + 32'd1;
        ma      = 33'(w_q.ph_len);
        mb      = 33'(nph);
        state_d = ST_GM1;
      end
      ST_GM1: begin
        gl_d    = p_q[63:47];
        word_d  = l_rdata;
        nph     = ~w_q.ph_life + 32'd1;
        ma      = 33'(w_q.ph_life);
        mb      = 33'(nph);
        state_d = ST_GM2;
      end
      ST_GM2: begin
        ma      = 33'(gl_q);
        mb      = 33'(p_q[63:47]);
        state_d = ST_GM3;
      end
      ST_GM3: begin
        g_d     = p_q[30:0];
        ma      = 33'($signed(word_q[15:0]));
        mb      = 33'(p_q[30:0]);
        state_d = ST_GM4;
      end
      ST_GM4: begin
        acc_l_d = acc_l_q + ACC_W'(p_q);
        ma      = 33'($signed(word_q[31:16]));
        mb      = 33'(g_q);
        state_d = ST_GM5;
      end
      ST_GM5: begin
        acc_r_d = acc_r_q + ACC_W'(p_q);
        g_we    = 1'b1;
        idx_d   = idx_q + GI'(1);
        state_d = ST_WALK;
      end
      ST_SPAWN: begin
        if (cd_q <= 17'sd0) begin
          cd_d = $signed({1'b0, spacing_q}) - 17'sd1;
          state_d = found_q ? ST_SM0 : ST_FINISH;
        end else begin
          cd_d    = cd_q - 17'sd1;
          state_d = ST_FINISH;
        end
      end
      ST_SM0: begin
        ma      = 33'(wi_q);
        mb      = 33'(fs_q);
        state_d = ST_SM1;
      end
      ST_SM1: begin
        st_raw_d = p_q[FA+15:3];
        ma       = 33'(glen_q);
        mb       = 33'(fl_q);
        state_d  = ST_SM2;
      end
      ST_SM2: begin
        siz_d   = p_q[31:3];
        ma      = 33'(glife_q);
        mb      = 33'(fd_q);
        state_d = ST_SM3;
      end
      ST_SM3: begin
        du_d    = p_q[31:3];
        ma      = 33'(speed_q);
        mb      = 33'(fp_q);
        state_d = ST_SM4;
      end
      ST_SM4: begin
        rate_d        = p_q[31] ? 16'hFFFF : p_q[30:15];
        div_req.start = 1'b1;
        div_req.num   = NUM_W'(st_raw_q);
        div_req.den   = DEN_W'(lq);
        state_d       = ST_DV0;
      end
      ST_DV0: begin
        if (div_rsp.done) begin
          st_d          = PW'(div_rsp.rem);
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(1) << 44;
          div_req.den   = DEN_W'(siz_q);
          state_d       = ST_DV1;
        end
      end
      ST_DV1: begin
        if (div_rsp.done) begin
          // one frame or less: the envelope never moves
          stl_d         = (siz_q > 29'd4096) ? div_rsp.quot[31:0] : '0;
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(1) << 44;
          div_req.den   = DEN_W'(du_q);
          state_d       = ST_DV2;
        end
      end
      ST_DV2: begin
        if (div_rsp.done) begin
          std_d   = (du_q > 29'd4096) ? div_rsp.quot[31:0] : '0;
          state_d = ST_SPWR;
        end
      end
      ST_SPWR: begin
        en_ext   = 34'(st_q) + 34'(siz_q);
        life_sum = 30'(du_q) + 30'd4095;
        g_wr.pos       = st_q;
        g_wr.beg_pos   = st_q;
        g_wr.end_pos   = (en_ext >= 34'(lq)) ? lq : EW'(en_ext);
        g_wr.life      = life_sum[28:12];
        g_wr.rate      = rate_q;
        g_wr.ph_len    = '0;
        g_wr.step_len  = stl_q;
        g_wr.ph_life   = '0;
        g_wr.step_life = std_q;
        g_we           = 1'b1;
        g_waddr        = free_q;
        live_d[free_q] = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        l_we   = ~freeze_q;
        wi_inc = (LW+1)'(wi_q) + (LW+1)'(1);
        if (wi_inc >= (LW+1)'(len_l)) begin
          wi_d = '0;
        end else begin
          wi_d = FA'(wi_inc);
        end
        ma      = 33'(ml_l);
        mb      = 33'(gain_q);
        state_d = ST_OUTL;
      end
      ST_OUTL: begin
        tmp_l_d = sat16(p_q);
        ma      = 33'(ml_r);
        mb      = 33'(gain_q);
        state_d = ST_OUTR;
      end
      ST_OUTR: begin
        // hold the right product until the output register frees up
        ma = 33'(ml_r);
        mb = 33'(gain_q);
        if (!m_valid_q || m_axis_tready) begin
          m_data_d  = {sat16(p_q), tmp_l_q};
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      idx_q     <= '0;
      free_q    <= '0;
      found_q   <= 1'b0;
      live_q    <= '0;
      wi_q      <= '0;
      cd_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      idx_q     <= idx_d;
      free_q    <= free_d;
      found_q   <= found_d;
      live_q    <= live_d;
      wi_q      <= wi_d;
      cd_q      <= cd_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      lft_q <= s_axis_tdata[15:0];
      rgt_q <= s_axis_tdata[31:16];
      // jitter factor 1 + r as an unsigned Q1.15 value
      fs_q  <= {~s_axis_tdata[47], s_axis_tdata[46:32]};
      fp_q  <= {~s_axis_tdata[63], s_axis_tdata[62:48]};
      fl_q  <= {~s_axis_tdata[79], s_axis_tdata[78:64]};
      fd_q  <= {~s_axis_tdata[95], s_axis_tdata[94:80]};
    end
    acc_l_q  <= acc_l_d;
    acc_r_q  <= acc_r_d;
    w_q      <= w_d;
    gl_q     <= gl_d;
    g_q      <= g_d;
    word_q   <= word_d;
    st_raw_q <= st_raw_d;
    siz_q    <= siz_d;
    du_q     <= du_d;
    rate_q   <= rate_d;
    st_q     <= st_d;
    stl_q    <= stl_d;
    std_q    <= std_d;
    tmp_l_q  <= tmp_l_d;
    m_data_q <= m_data_d;
    p_q      <= ma * mb;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  glp_ram #(
    .W (GW),
    .D (MAX_GRAINS)
  ) u_grain_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (GW'(g_wr)),
    .raddr_i (idx_q[GA-1:0]),
    .rdata_o (g_rdata)
  );

  glp_ram #(
    .W (32),
    .D (LOOP_FRAMES)
  ) u_loop_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (w_q.pos[PW-1:12]),
    .rdata_o (l_rdata)
  );

  glp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  `GLP_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while an item is in work")
  `GLP_ASSERT_IMPL(a_div_done_expected, div_rsp.done, state_q == ST_DV0 || state_q == ST_DV1 || state_q == ST_DV2, "divider finished outside a division step")
  `GLP_ASSERT_IMPL(a_out_from_final, $rose(m_axis_tvalid), $past(state_q == ST_OUTR), "result raised outside the final step")

endmodule
